FILE: rtl/svpwm_pkg.sv
// Package: payload words, register indexes, constants and the sector lookup for the SVPWM core.
package svpwm_pkg;

    // Width of the duty outputs; saturation follows from it
    localparam int DATA_WIDTH = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DC_BUS     = 2'd1;

    // Register reset values
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;
    localparam logic [15:0] DC_BUS_RESET     = 16'd9216;

    // Q16 constants: sqrt3/2 and sqrt3
    localparam logic [16:0] K_SQRT3_2_Q16 = 17'd56756;
    localparam logic [16:0] K_SQRT3_Q16   = 17'd113512;

    // Sector codes
    localparam logic [2:0] SECTOR_NONE  = 3'd0;
    localparam logic [2:0] SECTOR_RESET = 3'd1;

    typedef struct packed {
        logic signed [15:0] u_alpha_in;
        logic signed [15:0] u_beta_in;
    } t_svpwm_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] duty_a;
        logic signed [DATA_WIDTH-1:0] duty_b;
        logic signed [DATA_WIDTH-1:0] duty_c;
        logic [2:0]                   sector_out;
    } t_svpwm_out;

    // Map the sign pattern {u3>0, u2>0, u1>0} to a sector; no valid pattern gives SECTOR_NONE
    function automatic logic [2:0] code_to_sector(input logic [2:0] code);
        logic [2:0] sec;
        unique case (code)
            3'd1:    sec = 3'd2;
            3'd2:    sec = 3'd6;
            3'd3:    sec = 3'd1;
            3'd4:    sec = 3'd4;
            3'd5:    sec = 3'd3;
            3'd6:    sec = 3'd5;
            default: sec = SECTOR_NONE;
        endcase
        return sec;
    endfunction

endpackage

FILE: rtl/svpwm_duty_generator_core.sv
// SVPWM duty generator: sector search, shared multiplier and bit-serial divider under one sequencer.
// Each word passes through two 33-step radix-2 divisions (one per active vector time), four multiplier
// passes, the sector step, two divider-load steps, the zero-time and duty steps, and the idle state that takes
// the word; no new word is taken before the result of the last has gone to the output register.
// The duty step waits while the output register is full.
// A new input word is taken while the previous result still waits in the output register.
// Reset (synchronous, active low): sequencer idle, output empty, held sector 1, period 1000,
// bus voltage 9216.
module svpwm_duty_generator_core
    import svpwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_svpwm_in            i_in,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_svpwm_out           o_out
);

    localparam int MA_W  = 33;            // multiplier operand A
    localparam int MB_W  = 17;            // multiplier operand B
    localparam int PR_W  = MA_W + MB_W;   // product
    localparam int QW    = 33;            // quotient bits
    localparam int UW    = 18;            // signed u values
    localparam int TW    = 36;            // signed time sums
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);

    localparam logic signed [TW-1:0] SAT_HI =
        TW'((longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1));
    localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MXA,
        S_MP,
        S_SECT,
        S_MA,
        S_MB,
        S_LD,
        S_DIV,
        S_T7,
        S_DUTY
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0] r_period;
    logic [15:0] r_dc_bus;

    // datapath registers
    logic signed [15:0]    r_alpha;
    logic signed [15:0]    r_beta;
    logic [PR_W-1:0]       r_prod;
    logic signed [16:0]    r_xa;
    logic [MA_W-1:0]       r_p;
    logic signed [UW-1:0]  r_ua;
    logic signed [UW-1:0]  r_ub;
    logic [2:0]            r_sector;
    logic                  r_phase;
    logic                  r_neg;
    logic [QW-1:0]         r_dq;
    logic [15:0]           r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [TW-1:0]  r_ta;
    logic signed [TW-1:0]  r_tb;
    logic signed [TW-1:0]  r_t7;
    logic                  r_out_valid;
    t_svpwm_out            r_out;

    // combinational signals
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [PR_W-1:0]       n_prod;
    logic signed [16:0]    alpha_ext;
    logic [16:0]           alpha_mag;
    logic signed [16:0]    xa_mag;
    logic signed [16:0]    n_xa;
    logic signed [16:0]    beta_ext;
    logic signed [16:0]    hb_adj;
    logic signed [16:0]    hb;
    logic signed [UW-1:0]  u1;
    logic signed [UW-1:0]  u2;
    logic signed [UW-1:0]  u3;
    logic [2:0]            sign_code;
    logic [2:0]            found_sector;
    logic [2:0]            n_sector;
    logic signed [UW-1:0]  n_ua;
    logic signed [UW-1:0]  n_ub;
    logic signed [UW-1:0]  ua_abs;
    logic signed [UW-1:0]  ub_abs;
    logic [15:0]           udc;
    logic [16:0]           rem_sh;
    logic [16:0]           rem_sub;
    logic                  q_bit;
    logic [QW-1:0]         n_dq;
    logic signed [TW-1:0]  t_mag;
    logic signed [TW-1:0]  n_t;
    logic signed [TW-1:0]  t_sum;
    logic signed [TW-1:0]  t_adj;
    logic signed [TW-1:0]  n_t7;
    logic signed [TW-1:0]  full_t;
    logic signed [TW-1:0]  part_t;
    logic signed [TW-1:0]  raw_a;
    logic signed [TW-1:0]  raw_b;
    logic signed [TW-1:0]  raw_c;
    logic                  out_free;

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[DATA_WIDTH-1:0];
    endfunction

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PWM_PERIOD_RESET;
            r_dc_bus <= DC_BUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PWM_PERIOD: r_period <= i_cfg_wdata;
                REG_DC_BUS:     r_dc_bus <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Select operands of the shared multiplier
    always_comb begin
        alpha_ext = {r_alpha[15], r_alpha};
        alpha_mag = alpha_ext[16] ? 17'(-alpha_ext) : 17'(alpha_ext);
        ua_abs    = r_ua[UW-1] ? -r_ua : r_ua;
        ub_abs    = r_ub[UW-1] ? -r_ub : r_ub;
        case (r_state)
            S_MXA: begin
                mul_a = MA_W'(alpha_mag);
                mul_b = K_SQRT3_2_Q16;
            end
            S_MP: begin
                mul_a = MA_W'(K_SQRT3_Q16);
                mul_b = {1'b0, r_period};
            end
            S_MB: begin
                mul_a = r_p;
                mul_b = ub_abs[MB_W-1:0];
            end
            default: begin
                mul_a = r_p;
                mul_b = ua_abs[MB_W-1:0];
            end
        endcase
        n_prod = PR_W'(mul_a) * PR_W'(mul_b);
    end

    // Form xa, u1..u3, the sector and the two u values that feed the vector times
    always_comb begin
        xa_mag    = $signed({1'b0, r_prod[31:16]});
        n_xa      = r_alpha[15] ? -xa_mag : xa_mag;
        beta_ext  = {r_beta[15], r_beta};
        hb_adj    = beta_ext + 17'(r_beta[15]);
        hb        = hb_adj >>> 1;
        u1        = UW'(beta_ext);
        u2        = UW'(r_xa) - UW'(hb);
        u3        = -UW'(r_xa) - UW'(hb);
        sign_code = {(!u3[UW-1] && (u3 != '0)),
                     (!u2[UW-1] && (u2 != '0)),
                     (!u1[UW-1] && (u1 != '0))};
        found_sector = code_to_sector(sign_code);
        n_sector  = (found_sector != SECTOR_NONE) ? found_sector : r_sector;
        case (n_sector)
            3'd1: begin
                n_ua = u2;
                n_ub = u1;
            end
            3'd2: begin
                n_ua = -u2;
                n_ub = -u3;
            end
            3'd3: begin
                n_ua = u1;
                n_ub = u3;
            end
            3'd4: begin
                n_ua = -u1;
                n_ub = -u2;
            end
            3'd5: begin
                n_ua = u3;
                n_ub = u2;
            end
            default: begin
                n_ua = -u3;
                n_ub = -u1;
            end
        endcase
    end

    // One restoring divider step: quotient bits shift in where dividend bits leave
    always_comb begin
        udc     = (r_dc_bus == '0) ? 16'd1 : r_dc_bus;
        rem_sh  = {r_rem, r_dq[QW-1]};
        rem_sub = rem_sh - {1'b0, udc};
        q_bit   = (rem_sh >= {1'b0, udc});
        n_dq    = {r_dq[QW-2:0], q_bit};
        t_mag   = TW'({1'b0, n_dq});
        n_t     = r_neg ? -t_mag : t_mag;
    end

    // Zero time and the three channel times
    always_comb begin
        t_sum  = TW'({1'b0, r_period}) - r_ta - r_tb;
        t_adj  = t_sum + TW'(t_sum[TW-1]);
        n_t7   = t_adj >>> 1;
        full_t = r_ta + r_tb + r_t7;
        part_t = r_tb + r_t7;
        case (r_sector)
            3'd1: begin
                raw_a = full_t;
                raw_b = part_t;
                raw_c = r_t7;
            end
            3'd2: begin
                raw_a = part_t;
                raw_b = full_t;
                raw_c = r_t7;
            end
            3'd3: begin
                raw_a = r_t7;
                raw_b = full_t;
                raw_c = part_t;
            end
            3'd4: begin
                raw_a = r_t7;
                raw_b = part_t;
                raw_c = full_t;
            end
            3'd5: begin
                raw_a = part_t;
                raw_b = r_t7;
                raw_c = full_t;
            end
            default: begin
                raw_a = full_t;
                raw_b = r_t7;
                raw_c = part_t;
            end
        endcase
        out_free = !r_out_valid || i_out_ready;
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sector    <= SECTOR_RESET;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // drop the result word once taken, unless a new one replaces it now
            if (r_out_valid && i_out_ready && (r_state != S_DUTY)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_alpha <= i_in.u_alpha_in;
                        r_beta  <= i_in.u_beta_in;
                        r_phase <= 1'b0;
                        r_state <= S_MXA;
                    end
                end
                S_MXA: begin
                    r_prod  <= n_prod;
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_xa    <= n_xa;
                    r_prod  <= n_prod;
                    r_state <= S_SECT;
                end
                S_SECT: begin
                    r_p      <= r_prod[MA_W-1:0];
                    r_ua     <= n_ua;
                    r_ub     <= n_ub;
                    r_sector <= n_sector;
                    r_state  <= S_MA;
                end
                S_MA, S_MB: begin
                    r_prod  <= n_prod;
                    r_state <= S_LD;
                end
                S_LD: begin
                    // divide K*Ts*|u| / 65536 by the bus voltage
                    r_dq    <= r_prod[QW+15:16];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_neg   <= r_phase ? r_ub[UW-1] : r_ua[UW-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dq  <= n_dq;
                    r_rem <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        if (!r_phase) begin
                            r_ta    <= n_t;
                            r_phase <= 1'b1;
                            r_state <= S_MB;
                        end else begin
                            r_tb    <= n_t;
                            r_state <= S_T7;
                        end
                    end
                end
                S_T7: begin
                    r_t7    <= n_t7;
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out.duty_a     <= sat(raw_a);
                        r_out.duty_b     <= sat(raw_b);
                        r_out.duty_c     <= sat(raw_c);
                        r_out.sector_out <= r_sector;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sim/tb_svpwm_duty_generator_core.sv
// Testbench for the SVPWM duty generator core: random handshakes, shadow predictor, word checks.
`timescale 1ns / 100ps

module tb_svpwm_duty_generator_core;
    import svpwm_pkg::*;

    // Unused register slots; writes there must leave the block unchanged
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Sector codes
    localparam logic [2:0] SEC1 = 3'd1;
    localparam logic [2:0] SEC2 = 3'd2;
    localparam logic [2:0] SEC3 = 3'd3;
    localparam logic [2:0] SEC4 = 3'd4;
    localparam logic [2:0] SEC5 = 3'd5;
    localparam logic [2:0] SEC6 = 3'd6;

    localparam longint SQRT3_HALF_Q16 = longint'(K_SQRT3_2_Q16);
    localparam longint SQRT3_Q16      = longint'(K_SQRT3_Q16);

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 72;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_svpwm_in  i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_svpwm_out o_out;

    // Shadow of the block's registers and held sector
    logic [15:0] model_period = PWM_PERIOD_RESET;
    logic [15:0] model_bus = DC_BUS_RESET;
    logic [2:0]  model_sector = SECTOR_RESET;

    t_svpwm_in  pending_voltage_q[$];
    t_svpwm_out expected_duty_q[$];
    int         words_queued = 0;
    int         words_accepted = 0;
    int         fail_count = 0;
    int         idle_pct = 32;
    int         stall_cycles = 0;
    logic       in_fire = 1'b0;
    logic       out_fire = 1'b0;

    svpwm_duty_generator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Active vector time in ticks; a zero bus voltage counts as one LSB
    function automatic longint active_time(longint u);
        longint udc;
        longint num;
        udc = (model_bus == 16'd0) ? 64'sd1 : longint'(model_bus);
        num = SQRT3_Q16 * longint'(model_period) * u;
        return num / (udc * 65536);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] clamp_duty(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DATA_WIDTH-1:0];
    endfunction

    // Sector search, dwell times and compare values for one voltage word
    function automatic t_svpwm_out predict_duty(t_svpwm_in w);
        t_svpwm_out r;
        longint a, b, xa, hb, u1, u2, u3, ts, t1, t2, t0, da, db, dc;
        logic [2:0] signs;
        logic [2:0] sec;
        a  = w.u_alpha_in;
        b  = w.u_beta_in;
        xa = (a * SQRT3_HALF_Q16) / 65536;
        hb = b / 2;
        u1 = b;
        u2 = xa - hb;
        u3 = -xa - hb;
        ts = longint'(model_period);
        signs = {u3 > 0, u2 > 0, u1 > 0};
        case (signs)
            3'b011:  sec = SEC1;
            3'b001:  sec = SEC2;
            3'b101:  sec = SEC3;
            3'b100:  sec = SEC4;
            3'b110:  sec = SEC5;
            3'b010:  sec = SEC6;
            default: sec = SECTOR_NONE;
        endcase
        // Zero vector: keep the previous sector
        if (sec != SECTOR_NONE) model_sector = sec;
        case (model_sector)
            SEC1: begin
                t1 = active_time(u2);
                t2 = active_time(u1);
                t0 = (ts - t1 - t2) / 2;
                da = t1 + t2 + t0; db = t2 + t0; dc = t0;
            end
            SEC2: begin
                t1 = active_time(-u2);
                t2 = active_time(-u3);
                t0 = (ts - t1 - t2) / 2;
                da = t2 + t0; db = t1 + t2 + t0; dc = t0;
            end
            SEC3: begin
                t1 = active_time(u1);
                t2 = active_time(u3);
                t0 = (ts - t1 - t2) / 2;
                da = t0; db = t1 + t2 + t0; dc = t2 + t0;
            end
            SEC4: begin
                t1 = active_time(-u1);
                t2 = active_time(-u2);
                t0 = (ts - t1 - t2) / 2;
                da = t0; db = t2 + t0; dc = t1 + t2 + t0;
            end
            SEC5: begin
                t1 = active_time(u3);
                t2 = active_time(u2);
                t0 = (ts - t1 - t2) / 2;
                da = t2 + t0; db = t0; dc = t1 + t2 + t0;
            end
            default: begin
                model_sector = SEC6;
                t1 = active_time(-u3);
                t2 = active_time(-u1);
                t0 = (ts - t1 - t2) / 2;
                da = t1 + t2 + t0; db = t0; dc = t2 + t0;
            end
        endcase
        r.duty_a     = clamp_duty(da);
        r.duty_b     = clamp_duty(db);
        r.duty_c     = clamp_duty(dc);
        r.sector_out = model_sector;
        return r;
    endfunction

    // Moderate voltages most often, full-range words nearly as often, some near the zero vector
    function automatic t_svpwm_in random_voltage();
        t_svpwm_in w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            w.u_alpha_in = 16'($urandom);
            w.u_beta_in  = 16'($urandom);
        end else if (pick < 85) begin
            w.u_alpha_in = 16'(int'($urandom_range(24000)) - 12000);
            w.u_beta_in  = 16'(int'($urandom_range(24000)) - 12000);
        end else begin
            w.u_alpha_in = 16'(int'($urandom_range(6)) - 3);
            w.u_beta_in  = 16'(int'($urandom_range(6)) - 3);
        end
        return w;
    endfunction

    task automatic queue_voltage(int alpha, int beta);
        t_svpwm_in w;
        w.u_alpha_in = 16'(alpha);
        w.u_beta_in  = 16'(beta);
        pending_voltage_q.push_back(w);
        words_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_PWM_PERIOD) model_period = val;
        else if (idx == REG_DC_BUS) model_bus = val;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold off until every queued word has gone in and every result has come back
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_duty_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                               logic [DATA_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    // Input word accepted: advance the shadow model and record its result
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_duty_q.push_back(predict_duty(i_in));
            words_accepted++;
        end
    end

    // Drive the next voltage word; hold valid and payload until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_voltage_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in       <= pending_voltage_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_svpwm_out want;
        out_fire <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_duty_q.size() == 0) begin
                $display("%0t: result word with no prediction pending, actual %0d/%0d/%0d s%0d",
                         $time, o_out.duty_a, o_out.duty_b, o_out.duty_c, o_out.sector_out);
                fail_count++;
            end else begin
                want = expected_duty_q.pop_front();
                check_field("duty_a", want.duty_a, o_out.duty_a);
                check_field("duty_b", want.duty_b, o_out.duty_b);
                check_field("duty_c", want.duty_c, o_out.duty_c);
                check_field("sector_out", DATA_WIDTH'(want.sector_out),
                            DATA_WIDTH'(o_out.sector_out));
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [15:0] phase_period[NUM_PHASES];
        logic [15:0] phase_bus[NUM_PHASES];
        phase_period = '{16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd20000, 16'd1000, 16'd7};
        phase_bus    = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd9216, 16'd3000,
                         16'd65535};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset settings: field extremes, all six sectors,
        // zero vectors that keep the previous sector
        queue_voltage(32767, 32767);
        queue_voltage(-32768, -32768);
        queue_voltage(32767, -32768);
        queue_voltage(-32768, 32767);
        queue_voltage(32767, 0);
        queue_voltage(-32768, 0);
        queue_voltage(0, 32767);
        queue_voltage(0, -32768);
        queue_voltage(0, 0);
        queue_voltage(3464, 2000);
        queue_voltage(0, 4000);
        queue_voltage(0, 0);
        queue_voltage(-3464, 2000);
        queue_voltage(-3464, -2000);
        queue_voltage(1, -1);
        queue_voltage(0, -4000);
        queue_voltage(-1, 0);
        queue_voltage(3464, -2000);
        queue_voltage(0, 0);
        queue_voltage(1, 0);
        queue_voltage(0, 1);
        queue_voltage(-1, -1);
        queue_voltage(2, -1);
        queue_voltage(-1, 1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Registers change only while the core is empty
            write_reg(REG_PWM_PERIOD, phase_period[p]);
            write_reg(REG_DC_BUS, phase_bus[p]);
            write_reg((p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
            end_writes();
            // One phase runs both sides flat out
            idle_pct = (p == 3) ? 0 : 32;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                pending_voltage_q.push_back(random_voltage());
                words_queued++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_duty_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/svpwm_pkg.sv
rtl/svpwm_duty_generator_core.sv
sim/tb_svpwm_duty_generator_core.sv
